// ===== sv/tna_pkg.sv =====
// Shared constants for the triangle normal and area pipeline.
`default_nettype none
package tna_pkg;
	localparam int AREA_BITS = 36;
endpackage
`default_nettype wire

// ===== sv/tna_ifs.sv =====
// Valid/ready channel interfaces for triangle vertices and normal/area results.
`default_nettype none
interface tna_vtx_if #(parameter int W = 16);
	logic valid;
	logic ready;
	logic signed [W-1:0] a_x, a_y, a_z;
	logic signed [W-1:0] b_x, b_y, b_z;
	logic signed [W-1:0] c_x, c_y, c_z;
	modport source(output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, input ready);
	modport sink(input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, output ready);
endinterface

interface tna_res_if import tna_pkg::*; #(parameter int NW = 16);
	logic valid;
	logic ready;
	logic signed [NW-1:0] normal_x, normal_y, normal_z;
	logic [AREA_BITS-1:0] tri_area;
	logic degenerate;
	modport source(output valid, normal_x, normal_y, normal_z, tri_area, degenerate,
		input ready);
	modport sink(input valid, normal_x, normal_y, normal_z, tri_area, degenerate,
		output ready);
endinterface
`default_nettype wire

// ===== sv/tna_sqrt_cell.sv =====
// One digit cell of the pipelined integer square root chain.
`default_nettype none
module tna_sqrt_cell #(
	parameter int RW = 70,
	parameter int PW = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              valid_i,
	output logic                   ready_o,
	input  wire logic [RW-1:0]     rad_i,
	input  wire logic [RW/2+1:0]   rem_i,
	input  wire logic [RW/2-1:0]   root_i,
	input  wire logic [PW-1:0]     pay_i,
	output logic                   valid_o,
	input  wire logic              ready_i,
	output logic [RW-1:0]          rad_o,
	output logic [RW/2+1:0]        rem_o,
	output logic [RW/2-1:0]        root_o,
	output logic [PW-1:0]          pay_o
);
	localparam int SW = RW / 2;

	logic [SW+1:0] remx, trial;
	logic          ge;
	logic          valid_q;

	// Only the low bits of the remainder can be set at this point of the chain.
	assign remx    = {rem_i[SW-1:0], rad_i[RW-1:RW-2]};
	assign trial   = {root_i, 2'b01};
	assign ge      = (remx >= trial);
	assign ready_o = !valid_q || ready_i;
	assign valid_o = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ready_o) begin
			valid_q <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_o) begin
			rad_o  <= {rad_i[RW-3:0], 2'b00};
			rem_o  <= ge ? (remx - trial) : remx;
			root_o <= {root_i[SW-2:0], ge};
			pay_o  <= pay_i;
		end
	end
endmodule
`default_nettype wire

// ===== sv/tna_div_cell.sv =====
// One quotient-bit cell of the three-lane restoring divider chain.
`default_nettype none
module tna_div_cell #(
	parameter int LW    = 35,
	parameter int QW    = 16,
	parameter int PW    = 8,
	parameter bit FIRST = 1'b0
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 valid_i,
	output logic                      ready_o,
	input  wire logic [LW-1:0]        len_i,
	input  wire logic [2:0][LW:0]     r_i,
	input  wire logic [2:0][QW-1:0]   q_i,
	input  wire logic [PW-1:0]        pay_i,
	output logic                      valid_o,
	input  wire logic                 ready_i,
	output logic [LW-1:0]             len_o,
	output logic [2:0][LW:0]          r_o,
	output logic [2:0][QW-1:0]        q_o,
	output logic [PW-1:0]             pay_o
);
	logic [2:0][LW:0] rs, rn;
	logic [2:0]       ge;
	logic             valid_q;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rs[i] = FIRST ? r_i[i] : {r_i[i][LW-1:0], 1'b0};
			ge[i] = (rs[i] >= {1'b0, len_i});
			rn[i] = ge[i] ? (rs[i] - {1'b0, len_i}) : rs[i];
		end
	end

	assign ready_o = !valid_q || ready_i;
	assign valid_o = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ready_o) begin
			valid_q <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_o) begin
			len_o <= len_i;
			pay_o <= pay_i;
			for (int i = 0; i < 3; i++) begin
				r_o[i] <= rn[i];
				q_o[i] <= {q_i[i][QW-2:0], ge[i]};
			end
		end
	end
endmodule
`default_nettype wire

// ===== sv/triangle_normal_and_area.sv =====
// Triangle face normal and area: top level pipeline.
// Usage: triangles arrive on the vtx channel, one transaction per triangle holding
// vertices A, B and C as signed fixed point with 10 fraction bits. Each triangle
// gives exactly one transaction on the res channel: the unit normal of (C-A)x(B-A)
// with NORMAL_FRAC_BITS fraction bits, the area in unsigned Q16.20 (saturating),
// and a degenerate flag that is set when the cross product is zero, in which case
// normal and area are zero.
// Throughput is one triangle per cycle unless the receiver stalls. The pipeline
// is five front stages (edges, products, cross product, partial squares, sum of
// squares), one cell per root bit in the square root chain, one cell per
// quotient bit in the divider chain, and the output register.
// Every stage holds its transaction until the next one frees up, so when the
// receiver stalls the pipeline keeps filling its empty stages and vtx.ready drops
// only once all of them hold a triangle. No transaction is lost or repeated.
// Reset clears all valid flags; the pipeline comes up empty and ready.
`default_nettype none
module triangle_normal_and_area import tna_pkg::*; #(
	parameter int COORD_BITS       = 16,
	parameter int NORMAL_FRAC_BITS = 14
) (
	input wire logic clk,
	input wire logic arst_n,
	tna_vtx_if.sink   vtx,
	tna_res_if.source res
);
	localparam int C    = COORD_BITS;
	localparam int F    = NORMAL_FRAC_BITS;
	localparam int EW   = C + 1;
	localparam int PRW  = 2 * C + 2;
	localparam int NW   = 2 * C + 3;
	localparam int MW   = 2 * C + 2;
	localparam int H    = MW / 2;
	localparam int RW   = 2 * MW + 2;
	localparam int SW   = RW / 2;
	localparam int QW   = F + 2;
	localparam int SPW  = 3 * MW + 4;
	localparam int DPW  = 4;
	localparam int XW   = (SW > AREA_BITS) ? SW : AREA_BITS;

	// Stage enables: a stage loads when it is empty or its successor loads.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, ov_q;
	logic en1, en2, en3, en4, en5, en_out;
	logic sq_ready0, dv_ready0;

	// Stage 1: edges.
	logic signed [2:0][EW-1:0] e1_s1, e2_s1;
	// Stage 2: products of the cross product.
	logic signed [5:0][PRW-1:0] p_s2;
	// Stage 3: magnitudes and signs.
	logic [2:0][MW-1:0] m_s3;
	logic [2:0]         sg_s3;
	logic               dg_s3;
	// Stage 4: partial squares.
	logic [2:0][MW-1:0] m_s4;
	logic [2:0]         sg_s4;
	logic               dg_s4;
	logic [2:0][2*H-1:0] pp_hh_s4, pp_hl_s4, pp_ll_s4;
	// Stage 5: sum of squares.
	logic [RW-1:0]      sum_s5;
	logic [SPW-1:0]     spay_s5;

	logic signed [NW-1:0] n0, n1, n2;
	logic [2:0][NW-1:0]   nv;

	assign en_out = !ov_q || res.ready;
	assign en5    = !v_s5 || sq_ready0;
	assign en4    = !v_s4 || en5;
	assign en3    = !v_s3 || en4;
	assign en2    = !v_s2 || en3;
	assign en1    = !v_s1 || en2;
	assign vtx.ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en1) v_s1 <= vtx.valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			e1_s1[0] <= EW'(vtx.b_x) - EW'(vtx.a_x);
			e1_s1[1] <= EW'(vtx.b_y) - EW'(vtx.a_y);
			e1_s1[2] <= EW'(vtx.b_z) - EW'(vtx.a_z);
			e2_s1[0] <= EW'(vtx.c_x) - EW'(vtx.a_x);
			e2_s1[1] <= EW'(vtx.c_y) - EW'(vtx.a_y);
			e2_s1[2] <= EW'(vtx.c_z) - EW'(vtx.a_z);
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			p_s2[0] <= $signed(e2_s1[1]) * $signed(e1_s1[2]);
			p_s2[1] <= $signed(e2_s1[2]) * $signed(e1_s1[1]);
			p_s2[2] <= $signed(e2_s1[2]) * $signed(e1_s1[0]);
			p_s2[3] <= $signed(e2_s1[0]) * $signed(e1_s1[2]);
			p_s2[4] <= $signed(e2_s1[0]) * $signed(e1_s1[1]);
			p_s2[5] <= $signed(e2_s1[1]) * $signed(e1_s1[0]);
		end
	end

	assign n0 = {p_s2[0][PRW-1], p_s2[0]} - {p_s2[1][PRW-1], p_s2[1]};
	assign n1 = {p_s2[2][PRW-1], p_s2[2]} - {p_s2[3][PRW-1], p_s2[3]};
	assign n2 = {p_s2[4][PRW-1], p_s2[4]} - {p_s2[5][PRW-1], p_s2[5]};
	assign nv = {n2, n1, n0};

	always_ff @(posedge clk) begin
		if (en3) begin
			for (int i = 0; i < 3; i++) begin
				m_s3[i]  <= nv[i][NW-1] ? MW'(-nv[i]) : nv[i][MW-1:0];
				sg_s3[i] <= nv[i][NW-1];
			end
			dg_s3 <= (n0 == '0) && (n1 == '0) && (n2 == '0);
		end
	end

	// Each square is split into half-width partial products.
	always_ff @(posedge clk) begin
		if (en4) begin
			m_s4  <= m_s3;
			sg_s4 <= sg_s3;
			dg_s4 <= dg_s3;
			for (int i = 0; i < 3; i++) begin
				pp_hh_s4[i] <= m_s3[i][MW-1:H] * m_s3[i][MW-1:H];
				pp_hl_s4[i] <= m_s3[i][MW-1:H] * m_s3[i][H-1:0];
				pp_ll_s4[i] <= m_s3[i][H-1:0] * m_s3[i][H-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en5) begin
			sum_s5 <= ({2'b00, pp_hh_s4[0], pp_ll_s4[0]} + (RW'(pp_hl_s4[0]) << (H + 1)))
				+ ({2'b00, pp_hh_s4[1], pp_ll_s4[1]} + (RW'(pp_hl_s4[1]) << (H + 1)))
				+ ({2'b00, pp_hh_s4[2], pp_ll_s4[2]} + (RW'(pp_hl_s4[2]) << (H + 1)));
			spay_s5 <= {dg_s4, sg_s4, m_s4[2], m_s4[1], m_s4[0]};
		end
	end

	// Square root chain, one cell per root bit.
	logic [SW:0]            sq_v, sq_rdy;
	logic [SW:0][RW-1:0]    sq_rad;
	logic [SW:0][SW+1:0]    sq_rem;
	logic [SW:0][SW-1:0]    sq_root;
	logic [SW:0][SPW-1:0]   sq_pay;

	assign sq_v[0]    = v_s5;
	assign sq_rad[0]  = sum_s5;
	assign sq_rem[0]  = '0;
	assign sq_root[0] = '0;
	assign sq_pay[0]  = spay_s5;
	assign sq_ready0  = sq_rdy[0];
	assign sq_rdy[SW] = dv_ready0;

	for (genvar k = 0; k < SW; k++) begin : g_sqrt
		tna_sqrt_cell #(.RW(RW), .PW(SPW)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.valid_i (sq_v[k]),
			.ready_o (sq_rdy[k]),
			.rad_i   (sq_rad[k]),
			.rem_i   (sq_rem[k]),
			.root_i  (sq_root[k]),
			.pay_i   (sq_pay[k]),
			.valid_o (sq_v[k+1]),
			.ready_i (sq_rdy[k+1]),
			.rad_o   (sq_rad[k+1]),
			.rem_o   (sq_rem[k+1]),
			.root_o  (sq_root[k+1]),
			.pay_o   (sq_pay[k+1])
		);
	end

	// Divider chain: three lanes, one cell per quotient bit.
	logic [QW:0]                  dv_v, dv_rdy;
	logic [QW:0][SW-1:0]          dv_len;
	logic [QW:0][2:0][SW:0]       dv_r;
	logic [QW:0][2:0][QW-1:0]     dv_q;
	logic [QW:0][DPW-1:0]         dv_pay;
	logic [SPW-1:0]               sq_out;

	assign sq_out    = sq_pay[SW];
	assign dv_v[0]   = sq_v[SW];
	assign dv_len[0] = sq_root[SW];
	assign dv_q[0]   = '0;
	assign dv_pay[0] = sq_out[SPW-1:3*MW];
	assign dv_ready0 = dv_rdy[0];
	assign dv_rdy[QW] = en_out;
	for (genvar i = 0; i < 3; i++) begin : g_rinit
		assign dv_r[0][i] = (SW + 1)'(sq_out[i*MW +: MW]);
	end

	for (genvar k = 0; k < QW; k++) begin : g_div
		tna_div_cell #(.LW(SW), .QW(QW), .PW(DPW), .FIRST(k == 0)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.valid_i (dv_v[k]),
			.ready_o (dv_rdy[k]),
			.len_i   (dv_len[k]),
			.r_i     (dv_r[k]),
			.q_i     (dv_q[k]),
			.pay_i   (dv_pay[k]),
			.valid_o (dv_v[k+1]),
			.ready_i (dv_rdy[k+1]),
			.len_o   (dv_len[k+1]),
			.r_o     (dv_r[k+1]),
			.q_o     (dv_q[k+1]),
			.pay_o   (dv_pay[k+1])
		);
	end

	// Output stage: round half away from zero, clamp, apply sign, saturate area.
	logic [2:0][QW:0]   qp;
	logic [2:0][QW-1:0] qr, qc, qs;
	logic [XW-1:0]      half;
	logic [AREA_BITS-1:0] area;
	logic [DPW-1:0]     dpay;

	assign dpay = dv_pay[QW];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			qp[i] = {1'b0, dv_q[QW][i]} + (QW + 1)'(1);
			qr[i] = qp[i][QW:1];
			qc[i] = (qr[i] > (QW'(1) << F)) ? (QW'(1) << F) : qr[i];
			qs[i] = dpay[i] ? (QW'(0) - qc[i]) : qc[i];
		end
		half = XW'(dv_len[QW] >> 1);
		area = (half > XW'({AREA_BITS{1'b1}})) ? {AREA_BITS{1'b1}} : half[AREA_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (en_out) begin
			ov_q <= dv_v[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (en_out) begin
			if (dpay[3]) begin
				res.normal_x   <= '0;
				res.normal_y   <= '0;
				res.normal_z   <= '0;
				res.tri_area   <= '0;
				res.degenerate <= 1'b1;
			end else begin
				res.normal_x   <= qs[0];
				res.normal_y   <= qs[1];
				res.normal_z   <= qs[2];
				res.tri_area   <= area;
				res.degenerate <= 1'b0;
			end
		end
	end

	assign res.valid = ov_q;
endmodule
`default_nettype wire
